>>> rtl/stt_pkg.sv
package stt_pkg;

    localparam int POS_BITS   = 24;
    localparam int LEN_W      = POS_BITS + 1;
    localparam int FIELD_W    = 24;
    localparam int CMP_W      = (LEN_W > FIELD_W) ? LEN_W : FIELD_W;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [POS_BITS-1:0] POS_MAX   = {POS_BITS{1'b1}};
    localparam logic [FIELD_W-1:0]  FIELD_MAX = {FIELD_W{1'b1}};

    // lexer mode codes
    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_IDENT    = 3'd1;
    localparam logic [2:0] MODE_NUMBER   = 3'd2;
    localparam logic [2:0] MODE_STRING   = 3'd3;
    localparam logic [2:0] MODE_ESCAPE   = 3'd4;
    localparam logic [2:0] MODE_OPERATOR = 3'd5;

    // pending operator codes
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_EQ   = 3'd1;
    localparam logic [2:0] OP_BANG = 3'd2;
    localparam logic [2:0] OP_LT   = 3'd3;
    localparam logic [2:0] OP_GT   = 3'd4;
    localparam logic [2:0] OP_AMP  = 3'd5;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic               run_end;
    } t_token;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic logic [2:0] op_code(input logic [7:0] c);
        logic [2:0] op;
        op = OP_NONE;
        if (c == CH_EQ)   op = OP_EQ;
        if (c == CH_BANG) op = OP_BANG;
        if (c == CH_LT)   op = OP_LT;
        if (c == CH_GT)   op = OP_GT;
        if (c == CH_AMP)  op = OP_AMP;
        return op;
    endfunction

    // length of [s, e), zero when e lies before s
    function automatic logic [LEN_W-1:0] span(input logic [LEN_W-1:0] s,
                                              input logic [LEN_W-1:0] e);
        return (e >= s) ? (e - s) : '0;
    endfunction

    function automatic logic [FIELD_W-1:0] sat_field(input logic [LEN_W-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        return (ext > CMP_W'(FIELD_MAX)) ? FIELD_MAX : FIELD_W'(ext);
    endfunction

endpackage

>>> rtl/source_text_tokenizer.sv
// source text tokenizer
// input channel: i_valid / o_ready carry one text byte per transaction, with
// i_final_byte high on the last byte of a source. whitespace is dropped; each
// token comes out as one transaction on o_valid / i_ready with its start offset
// and length. o_run_end marks the last token caused by a given input byte.
// a byte causes zero, one or two tokens.
// a byte is captured in an input register and processed from there; its
// tokens are written into the token queue and shown from its head.
// throughput is one byte per cycle while bytes yield at most one token on
// average and the receiver is ready; the 4-entry token queue drains one token
// a cycle and a byte is processed only when two queue slots are free.
// a stalled receiver fills the queue, then the input register holds its byte
// and o_ready drops; nothing is lost.
// reset (synchronous, active low) empties the queue and input register, and
// returns to idle between tokens at offset zero. after a final byte the
// offset restarts at zero for the next source. offsets saturate at the top of
// the position range.
module source_text_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_token_start,
    output logic [23:0] o_token_length,
    output logic        o_run_end
);

    localparam int PB = stt_pkg::POS_BITS;
    localparam int LW = stt_pkg::LEN_W;

    logic                         r_in_valid;
    logic [7:0]                   r_byte;
    logic                         r_last;

    logic [2:0]                   r_mode, n_mode;
    logic [PB-1:0]                r_start, n_start;
    logic [PB-1:0]                r_pos, n_pos;
    logic [2:0]                   r_pend, n_pend;

    stt_pkg::t_token              r_fifo [stt_pkg::FIFO_DEPTH];
    logic [stt_pkg::PTR_W-1:0]    r_head, r_tail;
    logic [stt_pkg::CNT_W-1:0]    r_count;

    logic                         fire;
    logic                         pop;
    logic                         a_v, b_v, c_v, do_begin;
    logic [LW-1:0]                a_s, a_l, b_s, c_s, c_l;
    logic [7:0]                   c;
    logic [2:0]                   op;
    logic [7:0]                   second;
    stt_pkg::t_token              tok0, tok1;
    logic                         push0, push1;
    logic [1:0]                   n_push;

    assign fire    = r_in_valid && (r_count <= stt_pkg::CNT_W'(stt_pkg::FIFO_DEPTH - 2));
    assign o_ready = !r_in_valid || fire;
    assign o_valid = r_count != '0;
    assign pop     = o_valid && i_ready;

    assign o_token_start  = r_fifo[r_head].start;
    assign o_token_length = r_fifo[r_head].length;
    assign o_run_end      = r_fifo[r_head].run_end;

    always_comb begin
        c        = r_byte;
        op       = stt_pkg::op_code(c);
        second   = (r_pend == stt_pkg::OP_AMP) ? stt_pkg::CH_AMP : stt_pkg::CH_EQ;
        n_mode   = r_mode;
        n_start  = r_start;
        n_pend   = r_pend;
        a_v      = 1'b0;
        a_s      = LW'(r_start);
        a_l      = stt_pkg::span(LW'(r_start), LW'(r_pos));
        b_v      = 1'b0;
        b_s      = LW'(r_pos);
        c_v      = 1'b0;
        c_s      = LW'(r_start);
        c_l      = '0;
        do_begin = 1'b0;

        unique case (r_mode)
            stt_pkg::MODE_IDENT: begin
                if (!(stt_pkg::is_alpha(c) || stt_pkg::is_digit(c) || c == stt_pkg::CH_COLON)) begin
                    a_v      = 1'b1;
                    n_mode   = stt_pkg::MODE_IDLE;
                    do_begin = 1'b1;
                end
            end
            stt_pkg::MODE_NUMBER: begin
                if (!stt_pkg::is_digit(c)) begin
                    a_v      = 1'b1;
                    n_mode   = stt_pkg::MODE_IDLE;
                    do_begin = 1'b1;
                end
            end
            stt_pkg::MODE_STRING: begin
                if (c == stt_pkg::CH_QUOTE) begin
                    a_v    = 1'b1;
                    n_mode = stt_pkg::MODE_IDLE;
                end else if (c == stt_pkg::CH_BSL) begin
                    n_mode = stt_pkg::MODE_ESCAPE;
                end
            end
            stt_pkg::MODE_ESCAPE: begin
                n_mode = stt_pkg::MODE_STRING;
            end
            stt_pkg::MODE_OPERATOR: begin
                n_mode = stt_pkg::MODE_IDLE;
                n_pend = stt_pkg::OP_NONE;
                a_v    = 1'b1;
                if (c == second) begin
                    a_l = LW'(2);
                end else begin
                    a_l      = LW'(1);
                    do_begin = 1'b1;
                end
            end
            default: begin
                // unknown codes behave as idle
                n_mode   = stt_pkg::MODE_IDLE;
                do_begin = 1'b1;
            end
        endcase

        if (do_begin && !stt_pkg::is_space(c)) begin
            priority if (c == stt_pkg::CH_QUOTE) begin
                n_mode  = stt_pkg::MODE_STRING;
                n_start = (r_pos == stt_pkg::POS_MAX) ? r_pos : r_pos + PB'(1);
            end else if (stt_pkg::is_alpha(c)) begin
                n_mode  = stt_pkg::MODE_IDENT;
                n_start = r_pos;
            end else if (stt_pkg::is_digit(c)) begin
                n_mode  = stt_pkg::MODE_NUMBER;
                n_start = r_pos;
            end else if (op != stt_pkg::OP_NONE) begin
                n_mode  = stt_pkg::MODE_OPERATOR;
                n_pend  = op;
                n_start = r_pos;
            end else begin
                b_v = 1'b1;
            end
        end

        // end of source: flush what is open
        c_s = LW'(n_start);
        if (r_last) begin
            if (n_mode == stt_pkg::MODE_IDENT || n_mode == stt_pkg::MODE_NUMBER ||
                n_mode == stt_pkg::MODE_STRING || n_mode == stt_pkg::MODE_ESCAPE) begin
                c_v = 1'b1;
                c_l = stt_pkg::span(LW'(n_start), LW'(r_pos) + LW'(1));
            end else if (n_mode == stt_pkg::MODE_OPERATOR) begin
                c_v = 1'b1;
                c_l = LW'(1);
            end
            n_mode  = stt_pkg::MODE_IDLE;
            n_pend  = stt_pkg::OP_NONE;
            n_start = '0;
            n_pos   = '0;
        end else begin
            n_pos = (r_pos == stt_pkg::POS_MAX) ? r_pos : r_pos + PB'(1);
        end
    end

    // pack up to two tokens; the one-byte token and the flush never coincide
    always_comb begin
        tok1.start   = b_v ? stt_pkg::sat_field(b_s) : stt_pkg::sat_field(c_s);
        tok1.length  = b_v ? stt_pkg::sat_field(LW'(1)) : stt_pkg::sat_field(c_l);
        tok1.run_end = 1'b1;
        if (a_v) begin
            tok0.start   = stt_pkg::sat_field(a_s);
            tok0.length  = stt_pkg::sat_field(a_l);
            tok0.run_end = !(b_v || c_v);
        end else begin
            tok0 = tok1;
        end
        push0  = fire && (a_v || b_v || c_v);
        push1  = fire && a_v && (b_v || c_v);
        n_push = {1'b0, push0} + {1'b0, push1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= stt_pkg::MODE_IDLE;
            r_start    <= '0;
            r_pos      <= '0;
            r_pend     <= stt_pkg::OP_NONE;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                r_mode  <= n_mode;
                r_start <= n_start;
                r_pos   <= n_pos;
                r_pend  <= n_pend;
            end
            if (pop) begin
                r_head <= r_head + stt_pkg::PTR_W'(1);
            end
            r_tail  <= r_tail + stt_pkg::PTR_W'(n_push);
            r_count <= r_count + stt_pkg::CNT_W'(n_push) - stt_pkg::CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_text_byte;
            r_last <= i_final_byte;
        end
        if (push0) begin
            r_fifo[r_tail] <= tok0;
        end
        if (push1) begin
            r_fifo[r_tail + stt_pkg::PTR_W'(1)] <= tok1;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stt_pkg::CNT_W'(stt_pkg::FIFO_DEPTH))
        else $error("token queue count beyond depth");

    a_pend_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == stt_pkg::MODE_OPERATOR) == (r_pend != stt_pkg::OP_NONE))
        else $error("pending operator out of step with mode");

    a_final_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_last |=> r_pos == '0 && r_mode == stt_pkg::MODE_IDLE)
        else $error("final byte did not restart the source");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push1 |-> push0 && r_count <= stt_pkg::CNT_W'(stt_pkg::FIFO_DEPTH - 2))
        else $error("second token pushed without room");
`endif

endmodule
